// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: sv/dbfd_pkg.sv
// ----------------------------------------------------------------------------
// dbfd_pkg
// Types and constants of the dual bus frame duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none
package dbfd_pkg;
    localparam int DEVICES_DEF = 32;
    localparam logic [15:0] RST_NO_RX_TIMEOUT = 16'd2000;
    localparam logic [7:0]  RST_DUP_WINDOW = 8'd20;
    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
    localparam logic [0:0]  REG_NO_RX_TIMEOUT = 1'b0;
    localparam logic [0:0]  REG_DUP_WINDOW = 1'b1;
    localparam logic        ACT_FRAME = 1'b0;
    localparam logic        ACT_TICK = 1'b1;
    localparam int FRAME_W = 93;
    localparam int WAIT_W = 35;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FRD   = 6'b000010,
        ST_FWR   = 6'b000100,
        ST_SWEEP = 6'b001000,
        ST_SWWR  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;
endpackage
`default_nettype wire

// File: sv/dual_bus_frame_dedup_top.sv
// ----------------------------------------------------------------------------
// dual_bus_frame_dedup_top
// Duplicate filter for CAN frames received on two redundant buses.
// ----------------------------------------------------------------------------
// A frame transaction gives its result after memory read, status update and output
// (states FRD, FWR, OUT). A tick transaction runs the sweep, which reads one wait
// entry per cycle, and then goes through FWR and OUT.
// One item is in work at a time; the next is accepted only once the result
// is taken.
// Reset is synchronous, active low, and clears time, flags and all valid and error bits.
`default_nettype none
`include "assert_macros.svh"
module dual_bus_frame_dedup_top #(
    parameter int DEVICES = dbfd_pkg::DEVICES_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_we,
    input  wire  [0:0]   cfg_index,
    input  wire  [15:0]  cfg_wdata,
    input  wire          s_tvalid,
    output logic         s_tready,
    // tdata: bus[0], can_id[29:1], device[34:30], frame_data[98:35], zeros
    input  wire  [103:0] s_tdata,
    // tuser: action
    input  wire          s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // tdata: forward[0], dropped_duplicate[1], out_id[30:2], out_data[94:31],
    // bus_error[96:95], device_error[98:97], zeros
    output logic [103:0] m_tdata
);
    localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int EW = $clog2(2 * DEVICES);

    dbfd_pkg::state_t state_reg, state_next;
    logic [15:0] tmo_reg;
    logic [7:0]  win_reg;
    logic [31:0] time_reg, rx0_reg, rx1_reg;
    logic [1:0]  berr_reg;
    logic [2*DEVICES-1:0] fvalid_reg;
    logic [DEVICES-1:0]   wvalid_reg;
    logic [1:0] derr_reg [DEVICES];
    logic        bus_reg;
    logic [28:0] id_reg;
    logic [4:0]  dev_reg;
    logic [63:0] data_reg;
    logic [DW:0] cnt_reg;
    logic [103:0] out_reg;

    logic [EW-1:0] f_raddr, f_waddr;
    logic [dbfd_pkg::FRAME_W-1:0] f_rdata;
    logic f_we;
    logic [DW-1:0] w_raddr, w_waddr;
    logic [dbfd_pkg::WAIT_W-1:0] w_rdata, w_wdata;
    logic w_we;

    logic in_range;
    logic [DW-1:0] dev_i;
    logic [EW-1:0] oth_i, cur_i;
    logic is_dup;
    logic [DW-1:0] sw_i;
    logic [31:0] dl_diff;
    logic expired;
    logic [1:0] dev_err_out;
    logic tick_acc;
    logic in_sweep;

    assign in_range = {27'd0, dev_reg} < 32'(DEVICES);
    assign dev_i = DW'(dev_reg);
    assign cur_i = EW'({dev_reg, bus_reg});
    assign oth_i = EW'({dev_reg, ~bus_reg});
    assign sw_i = cnt_reg[DW-1:0];

    assign f_raddr = EW'({s_tdata[34:30], ~s_tdata[0]});
    assign f_waddr = cur_i;
    assign f_we = (state_reg == dbfd_pkg::ST_FRD) && in_range;
    assign is_dup = fvalid_reg[oth_i] && (f_rdata[28:0] == id_reg)
        && (f_rdata[92:29] == data_reg);

    assign w_raddr = (state_reg == dbfd_pkg::ST_SWWR) ? DW'(cnt_reg + 1'b1) : '0;
    assign dl_diff = time_reg - w_rdata[31:0] - 32'd1;
    assign expired = dl_diff < dbfd_pkg::HALF_RANGE;

    always_comb begin
        w_we = 1'b0;
        w_waddr = dev_i;
        w_wdata = {2'b00, bus_reg ^ 1'b1, time_reg + {24'd0, win_reg}};
        if (state_reg == dbfd_pkg::ST_FRD && in_range) w_we = 1'b1;
    end

    dbfd_ram #(.WIDTH(dbfd_pkg::FRAME_W), .DEPTH(2 * DEVICES)) u_frame_ram (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata({data_reg, id_reg}),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    dbfd_ram #(.WIDTH(dbfd_pkg::WAIT_W), .DEPTH(DEVICES)) u_wait_ram (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    assign s_tready = (state_reg == dbfd_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == dbfd_pkg::ST_OUT);
    assign m_tdata = out_reg;
    assign dev_err_out = in_range ? derr_reg[dev_i] : 2'b00;
    assign tick_acc = s_tvalid && s_tready && (s_tuser == dbfd_pkg::ACT_TICK);
    assign in_sweep = (state_reg == dbfd_pkg::ST_SWEEP);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dbfd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == dbfd_pkg::ACT_TICK) ? dbfd_pkg::ST_SWEEP
                                                                 : dbfd_pkg::ST_FRD;
                end
            end
            dbfd_pkg::ST_FRD:   state_next = dbfd_pkg::ST_FWR;
            dbfd_pkg::ST_FWR:   state_next = dbfd_pkg::ST_OUT;
            dbfd_pkg::ST_SWEEP: state_next = dbfd_pkg::ST_SWWR;
            dbfd_pkg::ST_SWWR: begin
                if (cnt_reg == (DW+1)'(DEVICES - 1)) state_next = dbfd_pkg::ST_FWR;
            end
            dbfd_pkg::ST_OUT: begin
                if (m_tready) state_next = dbfd_pkg::ST_IDLE;
            end
            default: state_next = dbfd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dbfd_pkg::ST_IDLE;
            tmo_reg <= dbfd_pkg::RST_NO_RX_TIMEOUT;
            win_reg <= dbfd_pkg::RST_DUP_WINDOW;
            time_reg <= '0;
            rx0_reg <= '0;
            rx1_reg <= '0;
            berr_reg <= '0;
            fvalid_reg <= '0;
            wvalid_reg <= '0;
            cnt_reg <= '0;
            for (int i = 0; i < DEVICES; i++) derr_reg[i] <= 2'b00;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == dbfd_pkg::REG_NO_RX_TIMEOUT) tmo_reg <= cfg_wdata;
                else win_reg <= cfg_wdata[7:0];
            end
            case (state_reg)
                dbfd_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        bus_reg <= s_tdata[0];
                        id_reg <= s_tdata[29:1];
                        dev_reg <= s_tdata[34:30];
                        data_reg <= s_tdata[98:35];
                        cnt_reg <= '0;
                        if (s_tuser == dbfd_pkg::ACT_TICK) time_reg <= time_reg + 32'd1;
                    end
                end
                dbfd_pkg::ST_FRD: begin
                    if (bus_reg) rx1_reg <= time_reg;
                    else rx0_reg <= time_reg;
                    out_reg <= '0;
                    if (in_range) begin
                        fvalid_reg[cur_i] <= 1'b1;
                        if (is_dup) begin
                            wvalid_reg[dev_i] <= 1'b0;
                            derr_reg[dev_i][bus_reg] <= 1'b0;
                            out_reg[1] <= 1'b1;
                        end else begin
                            wvalid_reg[dev_i] <= 1'b1;
                            out_reg[0] <= 1'b1;
                            out_reg[30:2] <= id_reg;
                            out_reg[94:31] <= data_reg;
                        end
                    end
                end
                dbfd_pkg::ST_SWEEP: begin
                    berr_reg[0] <= (time_reg - rx0_reg) > {16'd0, tmo_reg};
                    berr_reg[1] <= (time_reg - rx1_reg) > {16'd0, tmo_reg};
                    out_reg <= '0;
                end
                dbfd_pkg::ST_SWWR: begin
                    if (wvalid_reg[sw_i] && expired) begin
                        derr_reg[sw_i][w_rdata[32]] <= 1'b1;
                        wvalid_reg[sw_i] <= 1'b0;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                dbfd_pkg::ST_FWR: begin
                    out_reg[96:95] <= berr_reg;
                    out_reg[98:97] <= dev_err_out;
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPL(a_one_busy, aclk, aresetn, !(s_tready && m_tvalid), "ready while busy")
    `ASSERT_IMPL(a_tick_out, aclk, aresetn, tick_acc |=> in_sweep, "tick did not start sweep")
    `ASSERT_IMPL(a_excl, aclk, aresetn, m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "fwd and drop")
endmodule
`default_nettype wire

// File: sv/dbfd_ram.sv
// ----------------------------------------------------------------------------
// dbfd_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module dbfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: tb/dedup_checker.sv
// ----------------------------------------------------------------------------
// Dual bus duplicate filter checker
// Watches the input and result streams of the dual bus frame duplicate filter
// and the register writes, keeps its own copy of the filter state, predicts
// the result of every accepted transaction and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dedup_checker (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_we,
    input  wire  [0:0]   cfg_index,
    input  wire  [15:0]  cfg_wdata,
    input  wire          s_tvalid,
    input  wire          s_tready,
    input  wire  [103:0] s_tdata,
    input  wire          s_tuser,
    input  wire          m_tvalid,
    input  wire          m_tready,
    input  wire  [103:0] m_tdata,
    output int           fail_count,
    output int           pending_count
);
    localparam int NDEV = dbfd_pkg::DEVICES_DEF;

    logic [15:0] silence_limit;
    logic [7:0]  dup_window;
    logic [31:0] now_ms;
    logic [31:0] last_seen [2];
    logic [1:0]  bus_flags;
    logic        copy_valid [2*NDEV];
    logic [28:0] copy_id [2*NDEV];
    logic [63:0] copy_data [2*NDEV];
    logic        waiting [NDEV];
    logic        wait_on [NDEV];
    logic [31:0] deadline [NDEV];
    logic [1:0]  dev_flags [NDEV];
    logic [98:0] expected_results [$];

    assign pending_count = expected_results.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic logic [98:0] filter_item(input logic act, input logic [103:0] d);
        logic        bus;
        logic [28:0] id;
        logic [4:0]  dev;
        logic [63:0] data;
        logic        fwd;
        logic        dup;
        int          cur;
        int          oth;
        bus = d[0];
        id = d[29:1];
        dev = d[34:30];
        data = d[98:35];
        fwd = 1'b0;
        dup = 1'b0;
        if (act == dbfd_pkg::ACT_TICK) begin
            now_ms = now_ms + 32'd1;
            for (int b = 0; b < 2; b++) begin
                bus_flags[b] = (now_ms - last_seen[b]) > {16'd0, silence_limit};
            end
            for (int k = 0; k < NDEV; k++) begin
                if (waiting[k] && (now_ms - deadline[k] - 32'd1) < dbfd_pkg::HALF_RANGE) begin
                    dev_flags[k][wait_on[k]] = 1'b1;
                    waiting[k] = 1'b0;
                end
            end
        end else begin
            last_seen[bus] = now_ms;
            cur = dev * 2 + bus;
            oth = dev * 2 + (bus ^ 1);
            if (copy_valid[oth] && copy_id[oth] == id && copy_data[oth] == data) begin
                dup = 1'b1;
                waiting[dev] = 1'b0;
                dev_flags[dev][bus] = 1'b0;
            end else begin
                fwd = 1'b1;
                waiting[dev] = 1'b1;
                wait_on[dev] = ~bus;
                deadline[dev] = now_ms + {24'd0, dup_window};
            end
            copy_valid[cur] = 1'b1;
            copy_id[cur] = id;
            copy_data[cur] = data;
        end
        return {dev_flags[dev], bus_flags, fwd ? data : 64'd0, fwd ? id : 29'd0, dup, fwd};
    endfunction

    always @(posedge aclk) begin
        logic [98:0] want;
        if (!aresetn) begin
            silence_limit <= dbfd_pkg::RST_NO_RX_TIMEOUT;
            dup_window <= dbfd_pkg::RST_DUP_WINDOW;
            now_ms = 0;
            last_seen[0] = 0;
            last_seen[1] = 0;
            bus_flags = 0;
            for (int k = 0; k < 2*NDEV; k++) copy_valid[k] = 1'b0;
            for (int k = 0; k < NDEV; k++) begin
                waiting[k] = 1'b0;
                dev_flags[k] = 2'b00;
            end
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == dbfd_pkg::REG_NO_RX_TIMEOUT) silence_limit <= cfg_wdata;
                else dup_window <= cfg_wdata[7:0];
            end
            if (s_tvalid && s_tready) expected_results.push_back(filter_item(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want[0])
                        report_mismatch("forward", 64'(m_tdata[0]), 64'(want[0]));
                    if (m_tdata[1] !== want[1])
                        report_mismatch("dropped_duplicate", 64'(m_tdata[1]), 64'(want[1]));
                    if (m_tdata[30:2] !== want[30:2])
                        report_mismatch("out_id", 64'(m_tdata[30:2]), 64'(want[30:2]));
                    if (m_tdata[94:31] !== want[94:31])
                        report_mismatch("out_data", m_tdata[94:31], want[94:31]);
                    if (m_tdata[96:95] !== want[96:95])
                        report_mismatch("bus_error", 64'(m_tdata[96:95]), 64'(want[96:95]));
                    if (m_tdata[98:97] !== want[98:97])
                        report_mismatch("device_error", 64'(m_tdata[98:97]), 64'(want[98:97]));
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Dual bus duplicate filter testbench
// Drives frames and millisecond ticks into the filter, with directed corner
// cases first and then mostly paired frames with random content, under
// several idle and stall patterns and register settings. The checker module
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [15:0]  cfg_wdata;
    logic         s_tvalid;
    wire          s_tready;
    logic [103:0] s_tdata;
    logic         s_tuser;
    wire          m_tvalid;
    logic         m_tready;
    wire  [103:0] m_tdata;
    int           fail_count;
    int           pending_count;
    int           gap_pct;
    int           stall_pct;
    int           hold_cycles;
    int           cycle_count;
    logic [28:0]  recent_id [32];
    logic [63:0]  recent_data [32];
    logic [31:0]  rnd_hi;

    dual_bus_frame_dedup_top uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata)
    );

    dedup_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .fail_count(fail_count),
        .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic act, input logic bus, input logic [28:0] id,
                             input logic [4:0] dev, input logic [63:0] data);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {5'd0, data, dev, id, bus};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item;
        logic [4:0]  dev;
        logic [28:0] id;
        logic [63:0] data;
        int          pick;
        dev = 5'($urandom_range(31));
        pick = $urandom_range(99);
        rnd_hi = $urandom;
        if (pick < 30) begin
            send_item(dbfd_pkg::ACT_TICK, 1'($urandom), 29'($urandom), dev,
                      {rnd_hi, 32'($urandom)});
        end else if (pick < 75) begin
            send_item(dbfd_pkg::ACT_FRAME, 1'($urandom), recent_id[dev], dev, recent_data[dev]);
        end else begin
            id = 29'($urandom);
            data = {rnd_hi, 32'($urandom)};
            if (pick < 80) data = data ^ (64'd1 << $urandom_range(63));
            recent_id[dev] = id;
            recent_data[dev] = data;
            send_item(dbfd_pkg::ACT_FRAME, 1'($urandom), id, dev, data);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b1;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        cycle_count = 0;
        for (int k = 0; k < 32; k++) begin
            recent_id[k] = 29'(k);
            recent_data[k] = 64'd0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(dbfd_pkg::ACT_FRAME, 1'b0, 29'h1FFFFFFF, 5'd31, 64'hFFFFFFFFFFFFFFFF);
        send_item(dbfd_pkg::ACT_FRAME, 1'b1, 29'h1FFFFFFF, 5'd31, 64'hFFFFFFFFFFFFFFFF);
        send_item(dbfd_pkg::ACT_FRAME, 1'b1, 29'd0, 5'd0, 64'd0);
        send_item(dbfd_pkg::ACT_FRAME, 1'b0, 29'd0, 5'd0, 64'd1);
        send_item(dbfd_pkg::ACT_FRAME, 1'b1, 29'd0, 5'd0, 64'd1);
        send_item(dbfd_pkg::ACT_FRAME, 1'b1, 29'd5, 5'd3, 64'h0123456789ABCDEF);
        send_item(dbfd_pkg::ACT_FRAME, 1'b0, 29'd5, 5'd3, 64'h0123456789ABCDEE);
        write_reg(dbfd_pkg::REG_DUP_WINDOW, 16'd1);
        write_reg(dbfd_pkg::REG_NO_RX_TIMEOUT, 16'd1);
        send_item(dbfd_pkg::ACT_FRAME, 1'b0, 29'd7, 5'd9, 64'd7);
        repeat (3) send_item(dbfd_pkg::ACT_TICK, 1'b0, 29'd0, 5'd9, 64'd0);
        send_item(dbfd_pkg::ACT_TICK, 1'b1, 29'h1FFFFFFF, 5'd3, 64'hFFFFFFFFFFFFFFFF);
        send_item(dbfd_pkg::ACT_FRAME, 1'b1, 29'd7, 5'd9, 64'd7);
        send_item(dbfd_pkg::ACT_TICK, 1'b0, 29'd0, 5'd9, 64'd0);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin gap_pct = 0; stall_pct = 0; end
                1: begin gap_pct = 64; stall_pct = 0; end
                2: begin gap_pct = 0; stall_pct = 64; end
                default: begin gap_pct = 21; stall_pct = 21; end
            endcase
            case (phase)
                1: begin
                    write_reg(dbfd_pkg::REG_NO_RX_TIMEOUT, 16'hFFFF);
                    write_reg(dbfd_pkg::REG_DUP_WINDOW, 16'd255);
                end
                3: begin
                    write_reg(dbfd_pkg::REG_NO_RX_TIMEOUT, 16'd3);
                    write_reg(dbfd_pkg::REG_DUP_WINDOW, 16'd2);
                end
                5: begin
                    write_reg(dbfd_pkg::REG_NO_RX_TIMEOUT, 16'd2000);
                    write_reg(dbfd_pkg::REG_DUP_WINDOW, 16'd20);
                end
                7: begin
                    write_reg(dbfd_pkg::REG_NO_RX_TIMEOUT, 16'($urandom_range(1, 40)));
                    write_reg(dbfd_pkg::REG_DUP_WINDOW, 16'($urandom_range(1, 10)));
                end
                default: ;
            endcase
            if (phase == 2) hold_cycles <= 400;
            for (int n = 0; n < 200; n++) random_item();
            if (phase == 4) drain_results();
        end

        drain_results();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
